/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

/* hdl/ipet_pkg.sv */
// ----------------------------------------------------------------------------
// ipet_pkg
// Types, constants and helpers of the IPv4 prefix exception table.
// ----------------------------------------------------------------------------
`default_nettype none

package ipet_pkg;

  localparam int unsigned ADDR_W            = 32;
  localparam int unsigned LEN_W             = 6;
  localparam int unsigned STATUS_W          = 2;
  localparam int unsigned TABLE_ENTRIES_DEF = 16;

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_CHECK = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BAD_PREFIX = 2'd1,
    STATUS_FULL       = 2'd2
  } status_e;

  // One request as it travels along the row of cells.
  typedef struct packed {
    logic              valid;
    op_e               op;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] mask;
    logic              bad;
    logic              done;
  } stage_t;

  // Leading ones mask; a length of zero gives an all-zero mask.
  function automatic logic [ADDR_W-1:0] make_mask(input logic [LEN_W-1:0] len);
    make_mask = ~({ADDR_W{1'b1}} >> len);
  endfunction

endpackage

`default_nettype wire

/* hdl/ipet_if.sv */
// ----------------------------------------------------------------------------
// ipet_if
// Valid/ready request and response channels of the prefix exception table.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipet_req_if;
  logic                             valid;
  logic                             ready;
  logic                             operation;
  logic [ipet_pkg::ADDR_W-1:0]      address;
  logic [ipet_pkg::LEN_W-1:0]       prefix_len;

  modport source (output valid, output operation, output address, output prefix_len,
                  input ready);
  modport sink   (input valid, input operation, input address, input prefix_len,
                  output ready);
endinterface

interface ipet_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [ipet_pkg::STATUS_W-1:0]    status;
  logic                             hit;

  modport source (output valid, output status, output hit, input ready);
  modport sink   (input valid, input status, input hit, output ready);
endinterface

`default_nettype wire

/* hdl/ipv4_prefix_exception_table.sv */
// ----------------------------------------------------------------------------
// ipv4_prefix_exception_table
// Table of IPv4 prefix exceptions built as a row of entry cells.
// ----------------------------------------------------------------------------
// Channel   Port    Direction  Payload
// request   req_i   in         operation, address, prefix_len
// response  rsp_o   out        status, hit
//
// One request enters per cycle while no response is held on the output; each
// passes one cell a cycle through that cell's stage register, and its response
// is then taken into the output register. Reset empties every entry at once. A
// response held on the output freezes the whole row and the request side.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_prefix_exception_table #(
  parameter int unsigned TABLE_ENTRIES = ipet_pkg::TABLE_ENTRIES_DEF
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  ipet_req_if.sink      req_i,
  ipet_rsp_if.source    rsp_o
);

  ipet_pkg::stage_t                  chain [TABLE_ENTRIES+1];
  logic                              en;
  logic                              rsp_valid_q;
  logic [ipet_pkg::STATUS_W-1:0]     status_q;
  logic                              hit_q;
  ipet_pkg::status_e                 status_d;
  logic                              hit_d;

  assign en          = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = en;

  always_comb begin
    chain[0].valid = req_i.valid;
    chain[0].op    = ipet_pkg::op_e'(req_i.operation);
    chain[0].addr  = req_i.address;
    chain[0].mask  = ipet_pkg::make_mask(req_i.prefix_len);
    chain[0].bad   = (req_i.prefix_len > ipet_pkg::LEN_W'(ipet_pkg::ADDR_W));
    chain[0].done  = 1'b0;
  end

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    ipet_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .stage_i (chain[i]),
      .stage_o (chain[i+1])
    );
  end

  always_comb begin
    status_d = ipet_pkg::STATUS_OK;
    hit_d    = 1'b0;
    if (chain[TABLE_ENTRIES].op == ipet_pkg::OP_ADD) begin
      if (chain[TABLE_ENTRIES].bad) begin
        status_d = ipet_pkg::STATUS_BAD_PREFIX;
      end else if (!chain[TABLE_ENTRIES].done) begin
        status_d = ipet_pkg::STATUS_FULL;
      end
    end else begin
      hit_d = chain[TABLE_ENTRIES].done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (en) begin
      rsp_valid_q <= chain[TABLE_ENTRIES].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      status_q <= status_d;
      hit_q    <= hit_d;
    end
  end

  assign rsp_o.valid  = rsp_valid_q;
  assign rsp_o.status = status_q;
  assign rsp_o.hit    = hit_q;

endmodule

`default_nettype wire

/* hdl/ipet_cell.sv */
// ----------------------------------------------------------------------------
// ipet_cell
// One table entry: claims a passing add if free, flags a passing check on match.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ipet_cell (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    en_i,
  input  wire ipet_pkg::stage_t  stage_i,
  output ipet_pkg::stage_t       stage_o
);

  logic                          entry_valid_q;
  logic [ipet_pkg::ADDR_W-1:0]   prefix_q;
  logic [ipet_pkg::ADDR_W-1:0]   mask_q;
  ipet_pkg::stage_t              stage_q;
  ipet_pkg::stage_t              stage_d;
  logic                          take;
  logic                          match;

  always_comb begin
    take = stage_i.valid && (stage_i.op == ipet_pkg::OP_ADD) && !stage_i.bad &&
           !stage_i.done && !entry_valid_q;
    match = entry_valid_q && ((stage_i.addr & mask_q) == prefix_q);
    stage_d = stage_i;
    if (stage_i.valid && (stage_i.op == ipet_pkg::OP_CHECK) && match) begin
      stage_d.done = 1'b1;
    end
    if (take) begin
      stage_d.done = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= 1'b0;
      stage_q       <= '0;
    end else if (en_i) begin
      stage_q <= stage_d;
      if (take) begin
        entry_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && take) begin
      prefix_q <= stage_i.addr & stage_i.mask;
      mask_q   <= stage_i.mask;
    end
  end

  assign stage_o = stage_q;

  `ASSERT_NEXT(a_entry_sticky, clk_i, rst_ni, entry_valid_q, entry_valid_q,
               "Entry lost its valid bit.")
  `ASSERT_NEXT(a_take_stores, clk_i, rst_ni, en_i && take,
               entry_valid_q && stage_q.done, "Add was not stored.")
  `ASSERT_NEXT(a_done_kept, clk_i, rst_ni, en_i && stage_i.valid && stage_i.done,
               stage_q.valid && stage_q.done, "Done flag dropped.")

endmodule

`default_nettype wire

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the IPv4 prefix exception table. Directed requests
// cover empty-table lookups, host and network prefixes, rejected prefix
// lengths, the catch-all zero-length prefix and a full table. Random add and
// lookup requests follow, most lookups aimed at stored prefixes with random
// host bits or a flipped network bit. A scoreboard keeps its own copy of the
// table and checks each response in order while both channels stall at random.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import ipet_pkg::*;

  localparam int unsigned ENTRIES         = TABLE_ENTRIES_DEF;
  localparam int unsigned RANDOM_REQUESTS = 630;
  localparam int unsigned TAIL_REQUESTS   = 50;
  localparam int unsigned IDLE_PERCENT    = 12;
  localparam int unsigned IDLE_LIMIT      = 2000;
  localparam int unsigned MAX_REPORTS     = 10;

  typedef struct {
    status_e status;
    logic    hit;
  } verdict_t;

  class prefix_table_scoreboard;
    logic [ADDR_W-1:0] stored_prefix [ENTRIES];
    logic [ADDR_W-1:0] stored_mask [ENTRIES];
    bit                stored_valid [ENTRIES];
    int unsigned       fill;
    int unsigned       mismatches;
    verdict_t          expected_verdicts [$];

    function void note_request(op_e op, logic [ADDR_W-1:0] addr, logic [LEN_W-1:0] len);
      verdict_t          v;
      logic [ADDR_W-1:0] m;
      v.status = STATUS_OK;
      v.hit    = 1'b0;
      if (op == OP_ADD) begin
        if (len > ADDR_W) begin
          v.status = STATUS_BAD_PREFIX;
        end else if (fill >= ENTRIES) begin
          v.status = STATUS_FULL;
        end else begin
          m = '0;
          for (int i = 0; i < len; i++) m[ADDR_W-1-i] = 1'b1;
          stored_prefix[fill] = addr & m;
          stored_mask[fill]   = m;
          stored_valid[fill]  = 1'b1;
          fill++;
        end
      end else begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (stored_valid[i] && (addr & stored_mask[i]) == stored_prefix[i]) v.hit = 1'b1;
        end
      end
      expected_verdicts.push_back(v);
    endfunction

    function void check_response(logic [STATUS_W-1:0] status, logic hit);
      verdict_t v;
      if (expected_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%t: response with none outstanding: status %0d hit %0b",
                   $realtime, status, hit);
        return;
      end
      v = expected_verdicts.pop_front();
      if (status !== v.status || hit !== v.hit) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%t: response mismatch: status exp %0d got %0d, hit exp %0b got %0b",
                   $realtime, v.status, status, v.hit, hit);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  bit          calm;
  bit          wrapping_up;
  int unsigned quiet_cycles;

  prefix_table_scoreboard board;

  ipet_req_if req_if ();
  ipet_rsp_if rsp_if ();

  ipv4_prefix_exception_table u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    rsp_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) board.check_response(rsp_if.status, rsp_if.hit);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (!wrapping_up && quiet_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_request(op_e op, logic [ADDR_W-1:0] addr, logic [LEN_W-1:0] len);
    while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.operation  <= op;
    req_if.address    <= addr;
    req_if.prefix_len <= len;
    do @(posedge clk_i); while (!req_if.ready);
    board.note_request(op, addr, len);
  endtask

  // An aimed lookup keeps the network part of a stored prefix and randomises
  // the host part; now and then one network bit is flipped to probe a near miss.
  task automatic send_lookup(bit aimed);
    logic [ADDR_W-1:0] a;
    int unsigned       e;
    int unsigned       ones;
    int unsigned       flip;
    a = $urandom();
    if (aimed && board.fill > 0) begin
      e    = $urandom_range(0, board.fill - 1);
      a    = board.stored_prefix[e] | (a & ~board.stored_mask[e]);
      ones = $countones(board.stored_mask[e]);
      if (ones > 0 && $urandom_range(0, 2) == 0) begin
        flip = $urandom_range(1, ones);
        a[ADDR_W-flip] = ~a[ADDR_W-flip];
      end
    end
    send_request(OP_CHECK, a, LEN_W'($urandom()));
  endtask

  task automatic send_add(int unsigned cap);
    logic [LEN_W-1:0] len;
    if (board.fill < cap && $urandom_range(0, 3) != 0) begin
      len = LEN_W'($urandom_range(2, ADDR_W));
    end else begin
      len = LEN_W'($urandom_range(ADDR_W + 1, (1 << LEN_W) - 1));
    end
    send_request(OP_ADD, $urandom(), len);
  endtask

  initial begin
    req_if.valid      = 1'b0;
    req_if.operation  = OP_ADD;
    req_if.address    = '0;
    req_if.prefix_len = '0;
    rsp_if.ready      = 1'b0;
    rst_ni            = 1'b0;
    calm              = 1'b0;
    wrapping_up       = 1'b0;
    quiet_cycles      = 0;
    board             = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(OP_CHECK, 32'h0000_0000, 6'd0);
    send_request(OP_CHECK, 32'hFFFF_FFFF, 6'd63);
    send_request(OP_ADD,   32'h0A00_0000, 6'd8);
    send_request(OP_ADD,   32'hC0A8_014D, 6'd32);
    send_request(OP_ADD,   32'hAC1F_FFFF, 6'd12);
    send_request(OP_ADD,   32'h0000_0001, 6'd31);
    send_request(OP_ADD,   32'h0102_0304, 6'd33);
    send_request(OP_ADD,   32'hFFFF_FFFF, 6'd63);
    send_request(OP_ADD,   32'h0000_0000, 6'd48);
    send_request(OP_CHECK, 32'h0AFF_0102, 6'd5);
    send_request(OP_CHECK, 32'h0B00_0000, 6'd0);
    send_request(OP_CHECK, 32'hC0A8_014D, 6'd32);
    send_request(OP_CHECK, 32'hC0A8_014C, 6'd42);
    send_request(OP_CHECK, 32'hAC10_0000, 6'd12);
    send_request(OP_CHECK, 32'hAC20_0000, 6'd12);
    send_request(OP_CHECK, 32'h0000_0000, 6'd31);
    send_request(OP_CHECK, 32'h0000_0002, 6'd31);
    send_request(OP_CHECK, 32'hFFFF_FFFE, 6'd21);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      calm <= (n >= 250 && n < 400);
      if ($urandom_range(0, 99) < 25) begin
        send_add(ENTRIES - 2);
      end else begin
        send_lookup($urandom_range(0, 99) < 65);
      end
    end
    calm <= 1'b0;

    // A one-bit prefix and then the catch-all prefix fill the last entries.
    send_lookup(1'b0);
    send_request(OP_ADD, $urandom(), 6'd1);
    send_lookup(1'b0);
    send_lookup(1'b0);
    send_request(OP_ADD, $urandom(), 6'd0);
    send_request(OP_CHECK, 32'h0000_0000, 6'd0);
    send_request(OP_CHECK, 32'hFFFF_FFFF, 6'd63);
    send_request(OP_ADD, 32'h0A00_0000, 6'd8);
    for (int n = 0; n < TAIL_REQUESTS; n++) begin
      if ($urandom_range(0, 99) < 40) begin
        send_add(ENTRIES + 1);
      end else begin
        send_lookup(1'($urandom_range(0, 1)));
      end
    end
    req_if.valid <= 1'b0;

    while (board.expected_verdicts.size() != 0) @(posedge clk_i);
    wrapping_up = 1'b1;
    repeat (ENTRIES + 4) @(posedge clk_i);
    if (board.mismatches == 0 && board.expected_verdicts.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
